>>> sv/anog_pkg.sv
// ============================================================================
// anog_pkg
// Shared widths, constants, codes and types of the audio noise gate.
// ============================================================================
`default_nettype none

package anog_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEFF_W    = 16;
    localparam int ENV_W      = COEFF_W + 1;
    localparam int THRESH_W   = SAMPLE_W - 1;
    localparam int HOLD_W     = 16;
    localparam int CNT_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MAG_W      = SAMPLE_W + 1;
    localparam int MUL_A_W    = ENV_W + 1;
    localparam int PROD_W     = 2 * MUL_A_W;

    // Envelope full scale and the open / close decision levels
    localparam int ENV_ONE_I     = 1 << COEFF_W;
    localparam int OPEN_LEVEL_I  = (ENV_ONE_I * 999 + 999) / 1000;
    localparam int CLOSE_LEVEL_I = (ENV_ONE_I + 999) / 1000;

    localparam logic [ENV_W-1:0] ENV_ONE     = ENV_W'(ENV_ONE_I);
    localparam logic [ENV_W-1:0] OPEN_LEVEL  = ENV_W'(OPEN_LEVEL_I);
    localparam logic [ENV_W-1:0] CLOSE_LEVEL = ENV_W'(CLOSE_LEVEL_I);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS  = 3'd4;

    // Gate phases
    localparam int PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_CLOSED  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ATTACK  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_OPEN    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_HOLD    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_RELEASE = 3'd4;

    typedef struct packed {
        logic [THRESH_W-1:0] threshold_level;
        logic [COEFF_W-1:0]  attack_coeff;
        logic [COEFF_W-1:0]  release_coeff;
        logic [HOLD_W-1:0]   hold_samples;
        logic [CNT_W-1:0]    channel_count;
    } cfg_t;

    // One classified frame as it waits between front and back
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_0;
        logic [SAMPLE_W-1:0] sample_1;
        logic                trig;
        logic                dual;
        logic                block_end;
    } frame_t;

endpackage

`default_nettype wire

>>> sv/anog_front.sv
// ============================================================================
// anog_front
// Accepts frames, compares each channel's magnitude with the threshold, flags the
// trigger and queues the classified frame in a two-entry queue for the back end.
// ============================================================================
`default_nettype none

module anog_front (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire  anog_pkg::cfg_t             cfg,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire  [2*anog_pkg::SAMPLE_W-1:0]  s_axis_tdata,   // sample_0, sample_1
    input  wire                              s_axis_tlast,   // block_end
    output logic                             q_valid,
    output anog_pkg::frame_t                 q_frame,
    input  wire                              q_pop
);

    logic [anog_pkg::SAMPLE_W-1:0] s0;
    logic [anog_pkg::SAMPLE_W-1:0] s1;
    logic [anog_pkg::MAG_W-1:0]    sx0;
    logic [anog_pkg::MAG_W-1:0]    sx1;
    logic [anog_pkg::MAG_W-1:0]    mag0;
    logic [anog_pkg::MAG_W-1:0]    mag1;
    logic [anog_pkg::MAG_W-1:0]    thr;
    logic                          dual;
    logic                          trig;
    logic                          push;
    anog_pkg::frame_t              new_frame;

    anog_pkg::frame_t entries_reg [2];
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;

    assign s0   = s_axis_tdata[anog_pkg::SAMPLE_W-1:0];
    assign s1   = s_axis_tdata[2*anog_pkg::SAMPLE_W-1:anog_pkg::SAMPLE_W];
    assign sx0  = {s0[anog_pkg::SAMPLE_W-1], s0};
    assign sx1  = {s1[anog_pkg::SAMPLE_W-1], s1};
    assign mag0 = s0[anog_pkg::SAMPLE_W-1] ? (~sx0 + anog_pkg::MAG_W'(1)) : sx0;
    assign mag1 = s1[anog_pkg::SAMPLE_W-1] ? (~sx1 + anog_pkg::MAG_W'(1)) : sx1;
    assign thr  = {2'b00, cfg.threshold_level};

    // Zero channels counts as one, three as two
    assign dual = cfg.channel_count[1];
    assign trig = (mag0 > thr) || (dual && (mag1 > thr));

    assign new_frame.sample_0  = s0;
    assign new_frame.sample_1  = s1;
    assign new_frame.trig      = trig;
    assign new_frame.dual      = dual;
    assign new_frame.block_end = s_axis_tlast;

    assign s_axis_tready = (count_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != 2'd0);
    assign q_frame       = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= new_frame;
        end
    end

endmodule

`default_nettype wire

>>> sv/anog_back.sv
// ============================================================================
// anog_back
// Runs the gate phase machine and envelope, then scales both channels with
// one shared multiplier and holds the result in an output register.
// ============================================================================
`default_nettype none

module anog_back (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire  anog_pkg::cfg_t             cfg,
    input  wire                              q_valid,
    input  wire  anog_pkg::frame_t           q_frame,
    output logic                             q_pop,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [2*anog_pkg::SAMPLE_W-1:0]  m_axis_tdata,   // gated_0, gated_1
    output logic                             m_axis_tuser,   // gate_open
    output logic                             m_axis_tlast    // block_end_out
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_MUL0 = 3'd2;
    localparam logic [2:0] ST_MUL1 = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    localparam int SW = anog_pkg::SAMPLE_W;
    localparam int EW = anog_pkg::ENV_W;
    localparam int CW = anog_pkg::COEFF_W;
    localparam int AW = anog_pkg::MUL_A_W;
    localparam int PW = anog_pkg::PROD_W;

    logic [2:0]                      state_reg;
    logic [2:0]                      state_next;
    logic [anog_pkg::PHASE_W-1:0]    phase_reg;
    logic [anog_pkg::PHASE_W-1:0]    phase_next;
    logic [EW-1:0]                   env_reg;
    logic [EW-1:0]                   env_next;
    logic [anog_pkg::HOLD_W-1:0]     hold_reg;
    logic [anog_pkg::HOLD_W-1:0]     hold_next;
    logic                            flag_reg;
    logic                            flag_next;
    logic                            out_valid_reg;

    anog_pkg::frame_t                item_reg;
    logic signed [PW-1:0]            prod_reg;
    logic [SW-1:0]                   gated0_reg;
    logic [2*SW-1:0]                 out_data_reg;
    logic                            out_flag_reg;
    logic                            out_last_reg;

    logic                            out_load;
    logic                            start;
    logic                            mul_en;
    logic signed [AW-1:0]            mul_a;
    logic signed [PW-1:0]            mul_p;
    logic [CW-1:0]                   coeff;
    logic [CW+EW:0]                  attack_sum;
    logic [EW-1:0]                   attack_env;
    logic [EW-1:0]                   release_env;
    logic [SW-1:0]                   gated1;

    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);
    assign start    = q_valid && ((state_reg == ST_IDLE) || out_load);
    assign q_pop    = start;
    assign mul_en   = start || (state_reg == ST_MUL0) || (state_reg == ST_MUL1);

    // Shared multiplier: envelope pole at start, then each channel
    assign coeff = (phase_reg == anog_pkg::PH_ATTACK) ? cfg.attack_coeff : cfg.release_coeff;

    always_comb
    begin
        unique case (state_reg)
            ST_MUL0: mul_a = AW'($signed(item_reg.sample_0));
            ST_MUL1: mul_a = AW'($signed(item_reg.sample_1));
            default: mul_a = $signed({2'b00, coeff});
        endcase
    end

    assign mul_p = mul_a * $signed({1'b0, env_reg});

    // Attack rounds up so the envelope always climbs toward full scale
    assign attack_sum  = {2'b00, prod_reg[2*CW-1:0]}
                       + {1'b0, (anog_pkg::ENV_ONE - {1'b0, cfg.attack_coeff}),
                          {CW{1'b1}}};
    assign attack_env  = attack_sum[CW+EW-1:CW];
    assign release_env = prod_reg[CW+EW-1:CW];

    always_comb
    begin
        phase_next = phase_reg;
        env_next   = env_reg;
        hold_next  = hold_reg;
        flag_next  = flag_reg;
        unique case (phase_reg)
            anog_pkg::PH_ATTACK:
            begin
                env_next = attack_env;
                if (attack_env >= anog_pkg::OPEN_LEVEL)
                begin
                    env_next   = anog_pkg::ENV_ONE;
                    phase_next = anog_pkg::PH_OPEN;
                    flag_next  = 1'b1;
                end
                if (!item_reg.trig)
                begin
                    phase_next = anog_pkg::PH_HOLD;
                    hold_next  = cfg.hold_samples;
                end
            end
            anog_pkg::PH_OPEN:
            begin
                env_next = anog_pkg::ENV_ONE;
                if (!item_reg.trig)
                begin
                    phase_next = anog_pkg::PH_HOLD;
                    hold_next  = cfg.hold_samples;
                end
            end
            anog_pkg::PH_HOLD:
            begin
                env_next = anog_pkg::ENV_ONE;
                priority if (item_reg.trig)
                begin
                    phase_next = anog_pkg::PH_OPEN;
                end
                else if (hold_reg <= anog_pkg::HOLD_W'(1))
                begin
                    hold_next  = '0;
                    phase_next = anog_pkg::PH_RELEASE;
                end
                else
                begin
                    hold_next = hold_reg - anog_pkg::HOLD_W'(1);
                end
            end
            anog_pkg::PH_RELEASE:
            begin
                env_next = release_env;
                if (release_env < anog_pkg::CLOSE_LEVEL)
                begin
                    env_next   = '0;
                    phase_next = anog_pkg::PH_CLOSED;
                    flag_next  = 1'b0;
                end
                if (item_reg.trig)
                begin
                    phase_next = anog_pkg::PH_ATTACK;
                end
            end
            default:
            begin
                phase_next = item_reg.trig ? anog_pkg::PH_ATTACK : anog_pkg::PH_CLOSED;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: state_next = q_valid ? ST_UPD : ST_IDLE;
            ST_UPD:  state_next = ST_MUL0;
            ST_MUL0: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = q_valid ? ST_UPD : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign gated1 = item_reg.dual ? prod_reg[CW+SW-1:CW] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= anog_pkg::PH_CLOSED;
            env_reg       <= '0;
            hold_reg      <= '0;
            flag_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_UPD)
            begin
                phase_reg <= phase_next;
                env_reg   <= env_next;
                hold_reg  <= hold_next;
                flag_reg  <= flag_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            item_reg <= q_frame;
        end
        if (mul_en)
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == ST_MUL1)
        begin
            gated0_reg <= prod_reg[CW+SW-1:CW];
        end
        if (out_load)
        begin
            out_data_reg <= {gated1, gated0_reg};
            out_flag_reg <= flag_reg;
            out_last_reg <= item_reg.block_end;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_flag_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> sv/audio_noise_gate_unit.sv
// ============================================================================
// audio_noise_gate_unit
// Noise gate with attack, hold and release over stereo audio frames.
// ============================================================================
// One frame enters on the s_axis channel (two Q1.15 samples, block end on
// tlast) and one gated frame leaves on m_axis (two scaled samples, gate-open
// flag on tuser, block end on tlast). The user must write registers through
// cfg_we, cfg_index and cfg_data only while no frame is in flight; the block
// itself does not enforce this. Unknown indexes are dropped.
// A front end classifies each frame against the threshold and places it in a
// two-entry queue. The back end then works on one frame at a time on its one
// shared 18x18 multiplier: envelope pole, state update, channel zero and
// channel one, then loads the output register. It takes the next waiting frame
// from the queue in the same cycle that it loads the output register.
// Reset clears the queue, the output valid flag and the gate (closed, envelope
// zero, hold zero, flag low) and loads the default register values.
// When the receiver stalls, the result holds in the output register, the back
// end waits with the next result ready, and the queue fills before tready
// drops.
`default_nettype none

module audio_noise_gate_unit (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_we,
    input  wire  [anog_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [anog_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [2*anog_pkg::SAMPLE_W-1:0]     s_axis_tdata,   // sample_0, sample_1
    input  wire                                 s_axis_tlast,   // block_end
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [2*anog_pkg::SAMPLE_W-1:0]     m_axis_tdata,   // gated_0, gated_1
    output logic                                m_axis_tuser,   // gate_open
    output logic                                m_axis_tlast    // block_end_out
);

    anog_pkg::cfg_t   cfg_reg;
    logic             q_valid;
    logic             q_pop;
    anog_pkg::frame_t q_frame;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_level <= anog_pkg::THRESH_W'(327);
            cfg_reg.attack_coeff    <= anog_pkg::COEFF_W'(64213);
            cfg_reg.release_coeff   <= anog_pkg::COEFF_W'(65480);
            cfg_reg.hold_samples    <= anog_pkg::HOLD_W'(2400);
            cfg_reg.channel_count   <= anog_pkg::CNT_W'(2);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                anog_pkg::REG_THRESHOLD:
                    cfg_reg.threshold_level <= cfg_data[anog_pkg::THRESH_W-1:0];
                anog_pkg::REG_ATTACK:
                    cfg_reg.attack_coeff <= cfg_data[anog_pkg::COEFF_W-1:0];
                anog_pkg::REG_RELEASE:
                    cfg_reg.release_coeff <= cfg_data[anog_pkg::COEFF_W-1:0];
                anog_pkg::REG_HOLD:
                    cfg_reg.hold_samples <= cfg_data[anog_pkg::HOLD_W-1:0];
                anog_pkg::REG_CHANNELS:
                    cfg_reg.channel_count <= cfg_data[anog_pkg::CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    anog_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_valid       (q_valid),
        .q_frame       (q_frame),
        .q_pop         (q_pop)
    );

    anog_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_frame       (q_frame),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the audio noise gate unit.
// ----------------------------------------------------------------------------
// A table of directed frames and register writes walks the gate through
// closed, attack, open, hold and release, then through the channel-count
// corner values. Random segments follow, each with a fresh register setting
// and bursts of loud, quiet and noisy frames. A bit-true gate model in this
// file predicts the gated frames that no table row gives; each result is
// checked field by field at the output. Sender and receiver stall at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import anog_pkg::*;

    localparam int                   NUM_ROWS      = 27;
    localparam int                   NUM_SEGMENTS  = 12;
    localparam int                   SEGMENT_ITEMS = 50;
    localparam int                   CYCLE_LIMIT   = 400000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 3'd5;

    typedef struct packed {
        logic [SAMPLE_W-1:0] gated_0;
        logic [SAMPLE_W-1:0] gated_1;
        logic                gate_open;
        logic                block_end;
    } gated_frame_t;

    typedef enum logic { ROW_FRAME, ROW_REG } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [SAMPLE_W-1:0]    word_a;     // sample_0 or register data
        logic [SAMPLE_W-1:0]    word_b;     // sample_1
        logic                   last;
        logic                   typed;
        gated_frame_t           want;
    } stim_row_t;

    logic                           clk           = 1'b0;
    logic                           rst_n         = 1'b0;
    logic                           cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]           cfg_index     = REG_THRESHOLD;
    logic [CFG_DATA_W-1:0]          cfg_data      = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [2*SAMPLE_W-1:0]          s_axis_tdata  = '0;    // sample_0, sample_1
    logic                           s_axis_tlast  = 1'b0;  // block_end
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [2*SAMPLE_W-1:0]          m_axis_tdata;          // gated_0, gated_1
    logic                           m_axis_tuser;          // gate_open
    logic                           m_axis_tlast;          // block_end_out

    // Gate model: register copies and state
    logic [THRESH_W-1:0]    thr_reg;
    logic [COEFF_W-1:0]     attack_reg;
    logic [COEFF_W-1:0]     release_reg;
    logic [HOLD_W-1:0]      hold_reg;
    logic [CNT_W-1:0]       chan_reg;
    logic [PHASE_W-1:0]     gate_phase;
    logic [ENV_W-1:0]       env_gain;
    logic [ENV_W-1:0]       hold_left;
    logic                   gate_flag;

    gated_frame_t   expected_frames[$];
    stim_row_t      directed_rows[0:NUM_ROWS-1];
    int             tx_idle_pct  = 23;
    int             rx_idle_pct  = 78;
    int             error_count  = 0;
    int             frame_no     = 0;
    int             cycle_count  = 0;

    audio_noise_gate_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d frames outstanding",
                     cycle_count, expected_frames.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [MAG_W-1:0] sample_mag(input logic [SAMPLE_W-1:0] s);
        return s[SAMPLE_W-1] ? (MAG_W'(0) - {1'b1, s}) : {1'b0, s};
    endfunction

    // floor(sample * env / 1.0), rounding toward minus infinity
    function automatic logic [SAMPLE_W-1:0] scale_sample(input logic [SAMPLE_W-1:0] s,
                                                         input logic [ENV_W-1:0] env);
        logic signed [2*SAMPLE_W+1:0] prod;
        prod = $signed(s) * $signed({1'b0, env});
        return prod[COEFF_W +: SAMPLE_W];
    endfunction

    function automatic gated_frame_t gate_frame(input logic [SAMPLE_W-1:0] s0,
                                                input logic [SAMPLE_W-1:0] s1,
                                                input logic blk);
        logic               dual;
        logic [MAG_W-1:0]   peak;
        logic               trig;
        logic [63:0]        acc;
        gated_frame_t       res;
        // zero channels counts as one, three as two
        dual = (chan_reg >= 2);
        peak = sample_mag(s0);
        if (dual && sample_mag(s1) > peak)
            peak = sample_mag(s1);
        trig = peak > MAG_W'(thr_reg);

        case (gate_phase)
            PH_ATTACK:
            begin
                acc = 64'(attack_reg) * 64'(env_gain)
                    + (64'(ENV_ONE) - 64'(attack_reg)) * 64'(ENV_ONE) + 64'(ENV_ONE) - 64'd1;
                env_gain = acc[COEFF_W +: ENV_W];
                if (env_gain >= OPEN_LEVEL)
                begin
                    env_gain   = ENV_ONE;
                    gate_phase = PH_OPEN;
                    gate_flag  = 1'b1;
                end
                if (!trig)
                begin
                    gate_phase = PH_HOLD;
                    hold_left  = ENV_W'(hold_reg);
                end
            end
            PH_OPEN:
            begin
                env_gain = ENV_ONE;
                if (!trig)
                begin
                    gate_phase = PH_HOLD;
                    hold_left  = ENV_W'(hold_reg);
                end
            end
            PH_HOLD:
            begin
                env_gain = ENV_ONE;
                if (trig)
                    gate_phase = PH_OPEN;
                else if (hold_left <= 1)
                begin
                    hold_left  = '0;
                    gate_phase = PH_RELEASE;
                end
                else
                    hold_left = hold_left - 1'b1;
            end
            PH_RELEASE:
            begin
                acc = 64'(release_reg) * 64'(env_gain);
                env_gain = acc[COEFF_W +: ENV_W];
                // below 0.001 of full scale: shut the gate
                if (64'(env_gain) * 64'd1000 < 64'(ENV_ONE))
                begin
                    env_gain   = '0;
                    gate_phase = PH_CLOSED;
                    gate_flag  = 1'b0;
                end
                if (trig)
                    gate_phase = PH_ATTACK;
            end
            default:
                gate_phase = trig ? PH_ATTACK : PH_CLOSED;
        endcase

        res.gated_0   = scale_sample(s0, env_gain);
        res.gated_1   = dual ? scale_sample(s1, env_gain) : '0;
        res.gate_open = gate_flag;
        res.block_end = blk;
        return res;
    endfunction

    // Loud magnitudes exceed the threshold, quiet ones do not
    function automatic logic [SAMPLE_W-1:0] make_sample(input bit loud);
        int unsigned        mag;
        logic [SAMPLE_W-1:0] v;
        if (loud)
            mag = $urandom_range(32768, int'(thr_reg) + 1);
        else
            mag = $urandom_range(int'(thr_reg), 0);
        v = mag[SAMPLE_W-1:0];
        if ($urandom_range(1))
            v = SAMPLE_W'(0) - v;
        return v;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_THRESHOLD: thr_reg     = data[THRESH_W-1:0];
            REG_ATTACK:    attack_reg  = data[COEFF_W-1:0];
            REG_RELEASE:   release_reg = data[COEFF_W-1:0];
            REG_HOLD:      hold_reg    = data[HOLD_W-1:0];
            REG_CHANNELS:  chan_reg    = data[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_frame(input logic [SAMPLE_W-1:0] s0, input logic [SAMPLE_W-1:0] s1,
                              input logic last, input logic typed, input gated_frame_t want);
        gated_frame_t predicted;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {s1, s0};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = gate_frame(s0, s1, last);
        expected_frames.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
    endtask

    // Result checker and receiver back-pressure
    always @(posedge clk)
    begin
        gated_frame_t got;
        gated_frame_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[SAMPLE_W-1:0], m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W],
                   m_axis_tuser, m_axis_tlast};
            if (expected_frames.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("frame %0d: unexpected result g0=%h g1=%h open=%b last=%b",
                             frame_no, got.gated_0, got.gated_1, got.gate_open, got.block_end);
            end
            else
            begin
                want = expected_frames.pop_front();
                if (got.gated_0 !== want.gated_0 || got.gated_1 !== want.gated_1 ||
                    got.gate_open !== want.gate_open || got.block_end !== want.block_end)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"frame %0d: expected g0=%h g1=%h open=%b last=%b, ",
                                  "got g0=%h g1=%h open=%b last=%b"}, frame_no,
                                 want.gated_0, want.gated_1, want.gate_open, want.block_end,
                                 got.gated_0, got.gated_1, got.gate_open, got.block_end);
                end
            end
            frame_no++;
        end
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial
    begin
        int                     items;
        int                     burst_len;
        int                     mode;
        bit                     loud_ch1;
        logic [SAMPLE_W-1:0]    s0;
        logic [SAMPLE_W-1:0]    s1;
        logic [CFG_DATA_W-1:0]  cfg_val[5];

        directed_rows = '{
            // after reset: closed goes to attack, envelope still zero
            '{ROW_FRAME, '0, 16'h7FFF, 16'h8000, 1'b1, 1'b1,
              '{16'h0000, 16'h0000, 1'b0, 1'b1}},
            // slow attack, quiet frame drops into hold
            '{ROW_FRAME, '0, 16'h0000, 16'h0000, 1'b0, 1'b1,
              '{16'h0000, 16'h0000, 1'b0, 1'b0}},
            '{ROW_FRAME, '0, 16'hFFFF, 16'h0001, 1'b0, 1'b0, '0},
            '{ROW_REG, REG_ATTACK,    16'h0000, '0, 1'b0, 1'b0, '0},
            '{ROW_REG, REG_HOLD,      16'h0000, '0, 1'b0, 1'b0, '0},
            '{ROW_REG, REG_RELEASE,   16'h0000, '0, 1'b0, 1'b0, '0},
            '{ROW_REG, REG_THRESHOLD, 16'h0000, '0, 1'b0, 1'b0, '0},
            '{ROW_FRAME, '0, 16'h8000, 16'h7FFF, 1'b1, 1'b0, '0},
            '{ROW_FRAME, '0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
            // zero hold: release on the first quiet hold frame
            '{ROW_FRAME, '0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
            '{ROW_FRAME, '0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
            '{ROW_FRAME, '0, 16'h0001, 16'h0000, 1'b0, 1'b0, '0},
            '{ROW_FRAME, '0, 16'h0005, 16'h0005, 1'b0, 1'b0, '0},
            '{ROW_FRAME, '0, 16'h0000, 16'h0000, 1'b1, 1'b0, '0},
            '{ROW_FRAME, '0, 16'h0064, 16'hFF9C, 1'b0, 1'b0, '0},
            // single channel: channel one ignored and zeroed
            '{ROW_REG, REG_CHANNELS,  16'h0001, '0, 1'b0, 1'b0, '0},
            '{ROW_FRAME, '0, 16'h0000, 16'h7FFF, 1'b0, 1'b0, '0},
            '{ROW_FRAME, '0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
            '{ROW_FRAME, '0, 16'h8000, 16'h0000, 1'b0, 1'b0, '0},
            // channel count zero acts as one
            '{ROW_REG, REG_CHANNELS,  16'h0000, '0, 1'b0, 1'b0, '0},
            '{ROW_FRAME, '0, 16'h0000, 16'h8000, 1'b0, 1'b0, '0},
            // channel count three acts as two
            '{ROW_REG, REG_CHANNELS,  16'hFFFF, '0, 1'b0, 1'b0, '0},
            '{ROW_FRAME, '0, 16'h0000, 16'h8000, 1'b0, 1'b0, '0},
            // write past the register list must change nothing
            '{ROW_REG, REG_UNUSED,    16'hFFFF, '0, 1'b0, 1'b0, '0},
            '{ROW_REG, REG_THRESHOLD, 16'hFFFF, '0, 1'b0, 1'b0, '0},
            '{ROW_FRAME, '0, 16'h8000, 16'h8000, 1'b1, 1'b0, '0},
            '{ROW_FRAME, '0, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, '0}
        };

        thr_reg     = THRESH_W'(327);
        attack_reg  = COEFF_W'(64213);
        release_reg = COEFF_W'(65480);
        hold_reg    = HOLD_W'(2400);
        chan_reg    = CNT_W'(2);
        gate_phase  = PH_CLOSED;
        env_gain    = '0;
        hold_left   = '0;
        gate_flag   = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            if (directed_rows[i].kind == ROW_REG)
            begin
                drain_results();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].word_a);
                // drop the enable only when no write follows in this step
                if (i == NUM_ROWS - 1 || directed_rows[i+1].kind == ROW_FRAME)
                    cfg_we <= 1'b0;
            end
            else
                send_frame(directed_rows[i].word_a, directed_rows[i].word_b,
                           directed_rows[i].last, directed_rows[i].typed,
                           directed_rows[i].want);
        end

        for (int seg = 0; seg < NUM_SEGMENTS; seg++)
        begin
            drain_results();
            if (seg < 4)
            begin
                tx_idle_pct = 23;
                rx_idle_pct = 78;
            end
            else if (seg < 8)
            begin
                tx_idle_pct = 78;
                rx_idle_pct = 23;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            if (seg == 0)
                cfg_val = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
            else if (seg == 1)
                cfg_val = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
            else
            begin
                cfg_val[0] = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3000));
                // mostly fast poles so the gate cycles through every phase
                for (int k = 1; k < 3; k++)
                    case ($urandom_range(3))
                        0:       cfg_val[k] = 16'h0000;
                        1:       cfg_val[k] = 16'($urandom);
                        default: cfg_val[k] = 16'($urandom_range(55000, 20000));
                    endcase
                cfg_val[3] = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(12));
                cfg_val[4] = 16'($urandom);
            end
            write_reg(REG_THRESHOLD, cfg_val[0]);
            write_reg(REG_ATTACK,    cfg_val[1]);
            write_reg(REG_RELEASE,   cfg_val[2]);
            write_reg(REG_HOLD,      cfg_val[3]);
            write_reg(REG_CHANNELS,  cfg_val[4]);
            cfg_we <= 1'b0;

            items = 0;
            while (items < SEGMENT_ITEMS)
            begin
                burst_len = $urandom_range(24, 1);
                mode      = $urandom_range(9);
                for (int j = 0; j < burst_len && items < SEGMENT_ITEMS; j++)
                begin
                    if (mode < 2)
                    begin
                        s0 = 16'($urandom);
                        s1 = 16'($urandom);
                    end
                    else if (mode < 6)
                    begin
                        loud_ch1 = (chan_reg >= 2) && $urandom_range(1);
                        s0 = make_sample(!loud_ch1);
                        s1 = loud_ch1 ? make_sample(1'b1) : 16'($urandom);
                    end
                    else
                    begin
                        s0 = make_sample(1'b0);
                        s1 = (chan_reg >= 2) ? make_sample(1'b0) : 16'($urandom);
                    end
                    send_frame(s0, s1, 1'($urandom_range(1)), 1'b0, '0);
                    items++;
                end
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (expected_frames.size() != 0)
        begin
            error_count++;
            $display("%0d expected frames never arrived", expected_frames.size());
        end
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
